// ----- design/pcfd_pkg.sv -----
`timescale 1ns / 1ps

package pcfd_pkg;

   localparam int CAP_W    = 16;
   localparam int TOTAL_W  = 17;
   localparam int FREQ_W   = 16;
   localparam int DUTY_W   = 14;
   localparam int CLK_W    = 25;
   localparam int SCALE_W  = 14;
   localparam int PROD_W   = SCALE_W + CAP_W;
   localparam int CSR_A_W  = 2;
   localparam int RSP_D_W  = 80;
   localparam int RSP_U_W  = 2;

   localparam logic [CLK_W-1:0]   CLK_HZ_RESET = CLK_W'(375000);
   localparam logic [SCALE_W-1:0] SCALE_RESET  = SCALE_W'(100);
   localparam logic [FREQ_W-1:0]  FREQ_MAX     = '1;

   typedef enum logic [CSR_A_W-1:0] {
      CSR_CLOCK_HZ   = 2'd0,
      CSR_DUTY_SCALE = 2'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_MUL,
      ST_DIV
   } state_type;

endpackage

// ----- design/pcfd_mul.sv -----
`timescale 1ns / 1ps

module pcfd_mul import pcfd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [SCALE_W-1:0] multiplicand,
   input  logic [CAP_W-1:0]   multiplier,
   output logic               busy,
   output logic [PROD_W-1:0]  product
);

   localparam int CNT_W = $clog2(CAP_W + 1);

   logic               busy_ff, busy_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SCALE_W-1:0] mcand_ff, mcand_in;
   logic [SCALE_W-1:0] upper_ff, upper_in;
   logic [CAP_W-1:0]   lower_ff, lower_in;
   logic [SCALE_W:0]   sum;

   // one multiplier bit per cycle, lsb first, partial sum shifts right
   always_comb begin
      sum      = {1'b0, upper_ff} + (lower_ff[0] ? {1'b0, mcand_ff} : '0);
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      mcand_in = mcand_ff;
      upper_in = upper_ff;
      lower_in = lower_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = CNT_W'(CAP_W);
         mcand_in = multiplicand;
         upper_in = '0;
         lower_in = multiplier;
      end else if (busy_ff) begin
         upper_in = sum[SCALE_W:1];
         lower_in = {sum[0], lower_ff[CAP_W-1:1]};
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      mcand_ff <= mcand_in;
      upper_ff <= upper_in;
      lower_ff <= lower_in;
   end

   assign busy    = busy_ff;
   assign product = {upper_ff, lower_ff};

endmodule

// ----- design/pcfd_div.sv -----
`timescale 1ns / 1ps

module pcfd_div import pcfd_pkg::*; #(
   parameter int QUOT_W = FREQ_W
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [TOTAL_W-1:0] divisor,
   input  logic [TOTAL_W-1:0] rem_init,
   input  logic [QUOT_W-1:0]  dividend_lo,
   output logic               busy,
   output logic [QUOT_W-1:0]  quotient
);

   localparam int CNT_W = $clog2(QUOT_W + 1);

   logic               busy_ff, busy_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [TOTAL_W-1:0] div_ff, div_in;
   logic [TOTAL_W-1:0] rem_ff, rem_in;
   logic [QUOT_W-1:0]  shift_ff, shift_in;
   logic [TOTAL_W+1:0] trial;
   logic               fits;

   // restoring division, one quotient bit per cycle; caller keeps rem_init < divisor, unchecked
   always_comb begin
      trial    = {1'b0, rem_ff, shift_ff[QUOT_W-1]} - {2'b00, div_ff};
      fits     = !trial[TOTAL_W+1];
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      shift_in = shift_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = CNT_W'(QUOT_W);
         div_in   = divisor;
         rem_in   = rem_init;
         shift_in = dividend_lo;
      end else if (busy_ff) begin
         rem_in   = fits ? trial[TOTAL_W-1:0] : {rem_ff[TOTAL_W-2:0], shift_ff[QUOT_W-1]};
         shift_in = {shift_ff[QUOT_W-2:0], fits};
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      div_ff   <= div_in;
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
   end

   assign busy     = busy_ff;
   assign quotient = shift_ff;

endmodule

// ----- design/pwm_capture_freq_duty.sv -----
`timescale 1ns / 1ps

// channel  direction  handshake                   payload
// req      in         req_tvalid / req_tready     tdata: capture_value
// rsp      out        rsp_tvalid / rsp_tready     tdata: widths, total, frequency, duty
//                                                 tuser: zero_period, stored_high
// csr      in         csr_valid / csr_ready       csr_addr, csr_wdata
//
// an item goes from accept to the next accept in steps: the sum, the multiplier, the start of the
// dividers, the dividers, the load into rsp, and the accept in idle.
// the 16-step frequency divider sets the divide phase; the duty divider runs beside it.
// reset is synchronous; registers return to 375000 Hz and a scale of 100.
// a result waiting on rsp does not block accepts; the load waits until the slot frees.

module pwm_capture_freq_duty import pcfd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [CAP_W-1:0]   req_tdata,    // [15:0] capture_value
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RSP_D_W-1:0] rsp_tdata,    // [15:0] high_width, [31:16] low_width,
                                            // [48:32] total_width, [64:49] frequency,
                                            // [78:65] duty, [79] pad
   output logic [RSP_U_W-1:0] rsp_tuser,    // [0] zero_period, [1] stored_high
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CSR_A_W-1:0] csr_addr,
   input  logic [CLK_W-1:0]   csr_wdata
);

   state_type state_ff, state_in;

   logic [CLK_W-1:0]   clk_hz_ff, clk_hz_in;
   logic [SCALE_W-1:0] scale_ff, scale_in;
   logic               next_high_ff, next_high_in;
   logic               went_high_ff, went_high_in;
   logic [CAP_W-1:0]   high_ff, high_in;
   logic [CAP_W-1:0]   low_ff, low_in;
   logic [TOTAL_W-1:0] total_ff, total_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_D_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_U_W-1:0] rsp_user_ff, rsp_user_in;

   logic               req_take;
   logic               mul_start, div_start, out_load;
   logic               mul_busy, fdiv_busy, ddiv_busy;
   logic [PROD_W-1:0]  product;
   logic [FREQ_W-1:0]  freq_q;
   logic [DUTY_W-1:0]  duty_q;
   logic               zero;
   logic               freq_sat;
   logic [FREQ_W-1:0]  freq_out;
   logic [DUTY_W-1:0]  duty_out;

   pcfd_mul u_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .multiplicand (scale_ff),
      .multiplier   (high_ff),
      .busy         (mul_busy),
      .product      (product)
   );

   pcfd_div #(.QUOT_W(FREQ_W)) u_fdiv (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .divisor     (total_ff),
      .rem_init    (TOTAL_W'(clk_hz_ff[CLK_W-1:FREQ_W])),
      .dividend_lo (clk_hz_ff[FREQ_W-1:0]),
      .busy        (fdiv_busy),
      .quotient    (freq_q)
   );

   pcfd_div #(.QUOT_W(DUTY_W)) u_ddiv (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .divisor     (total_ff),
      .rem_init    (TOTAL_W'(product[PROD_W-1:DUTY_W])),
      .dividend_lo (product[DUTY_W-1:0]),
      .busy        (ddiv_busy),
      .quotient    (duty_q)
   );

   // fsm outputs
   always_comb begin
      req_tready = 1'b0;
      mul_start  = 1'b0;
      div_start  = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_SUM:  mul_start  = 1'b1;
         ST_MUL:  div_start  = !mul_busy;
         ST_DIV:  out_load   = !fdiv_busy && !ddiv_busy && (!rsp_valid_ff || rsp_tready);
         default: ;
      endcase
   end

   // fsm next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_tvalid) begin
            state_in = ST_SUM;
         end
         ST_SUM:  state_in = ST_MUL;
         ST_MUL:  if (!mul_busy) begin
            state_in = ST_DIV;
         end
         ST_DIV:  if (out_load) begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_take  = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   always_comb begin
      clk_hz_in = clk_hz_ff;
      scale_in  = scale_ff;
      if (csr_valid) begin
         unique case (csr_addr)
            CSR_CLOCK_HZ:   clk_hz_in = csr_wdata;
            CSR_DUTY_SCALE: scale_in  = csr_wdata[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      next_high_in = next_high_ff;
      went_high_in = went_high_ff;
      high_in      = high_ff;
      low_in       = low_ff;
      total_in     = total_ff;
      if (req_take) begin
         next_high_in = !next_high_ff;
         went_high_in = next_high_ff;
         if (next_high_ff) begin
            high_in = req_tdata;
         end else begin
            low_in = req_tdata;
         end
      end
      if (mul_start) begin
         total_in = {1'b0, high_ff} + {1'b0, low_ff};
      end
   end

   // result assembly
   always_comb begin
      zero         = (total_ff == '0);
      freq_sat     = (TOTAL_W'(clk_hz_ff[CLK_W-1:FREQ_W]) >= total_ff);
      freq_out     = zero ? '0 : (freq_sat ? FREQ_MAX : freq_q);
      duty_out     = zero ? '0 : duty_q;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, duty_out, freq_out, total_ff, low_ff, high_ff};
         rsp_user_in  = {went_high_ff, zero};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clk_hz_ff    <= CLK_HZ_RESET;
         scale_ff     <= SCALE_RESET;
         next_high_ff <= 1'b1;
         high_ff      <= '0;
         low_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clk_hz_ff    <= clk_hz_in;
         scale_ff     <= scale_in;
         next_high_ff <= next_high_in;
         high_ff      <= high_in;
         low_ff       <= low_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      went_high_ff <= went_high_in;
      total_ff     <= total_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ----- design/pcfd_checker.sv -----
`timescale 1ns / 1ps

module pcfd_checker import pcfd_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_tvalid,
   input logic               req_tready,
   input logic               rsp_tvalid,
   input logic               rsp_tready,
   input logic [RSP_D_W-1:0] rsp_tdata,
   input logic [RSP_U_W-1:0] rsp_tuser
);

   // one item in flight: no accept right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted while an item is still in work");

   // a stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp beat changed while stalled");

   // zero period forces zero quotients and zero total
   a_zero_period: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[78:32] == '0)
      else $error("zero period with nonzero results");

   // total is the sum of both widths
   a_total: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[48:32] == {1'b0, rsp_tdata[15:0]} + {1'b0, rsp_tdata[31:16]})
      else $error("total width mismatch");

endmodule

bind pwm_capture_freq_duty pcfd_checker u_pcfd_checker (.*);

// ----- dv/pwm_capture_freq_duty_test.sv -----
`timescale 1ns / 1ps

module pwm_capture_freq_duty_test;
   import pcfd_pkg::*;

   localparam int                 CYCLE_LIMIT  = 1_000_000;
   localparam int                 DRAIN_CYCLES = 40;
   localparam logic [CSR_A_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_A_W-1:0] CSR_SPARE_HI = 2'd3;
   localparam logic [CLK_W-1:0]   CLK_HZ_TOP   = CLK_W'(24_000_000);
   localparam logic [SCALE_W-1:0] SCALE_TOP    = SCALE_W'(10_000);

   typedef struct packed {
      logic [CAP_W-1:0]   high_width;
      logic [CAP_W-1:0]   low_width;
      logic [TOTAL_W-1:0] total_width;
      logic [FREQ_W-1:0]  frequency;
      logic [DUTY_W-1:0]  duty;
      logic               zero_period;
      logic               stored_high;
   } pwm_reading_type;

   class pwm_reading_checker;
      logic [CLK_W-1:0]   clock_hz;
      logic [SCALE_W-1:0] scale;
      logic               next_high;
      logic [CAP_W-1:0]   high_slot;
      logic [CAP_W-1:0]   low_slot;
      pwm_reading_type    due_readings[$];
      int                 errors;
      int                 captures;
      int                 readings;

      function new();
         clock_hz  = CLK_HZ_RESET;
         scale     = SCALE_RESET;
         next_high = 1'b1;
         high_slot = '0;
         low_slot  = '0;
         errors    = 0;
         captures  = 0;
         readings  = 0;
      endfunction

      function void set_register(logic [CSR_A_W-1:0] index, logic [CLK_W-1:0] value);
         case (index)
            CSR_CLOCK_HZ: begin
               clock_hz = value;
            end
            CSR_DUTY_SCALE: begin
               scale = value[SCALE_W-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      function void log_capture(logic [CAP_W-1:0] capture);
         pwm_reading_type   r;
         logic [63:0]       quotient;
         r = '0;
         r.stored_high = next_high;
         if (next_high) high_slot = capture;
         else low_slot = capture;
         next_high = !next_high;
         r.high_width  = high_slot;
         r.low_width   = low_slot;
         r.total_width = TOTAL_W'(high_slot) + TOTAL_W'(low_slot);
         if (r.total_width == '0) begin
            r.zero_period = 1'b1;
         end else begin
            quotient = 64'(clock_hz) / 64'(r.total_width);
            r.frequency = (quotient > 64'(FREQ_MAX)) ? FREQ_MAX : quotient[FREQ_W-1:0];
            quotient = (64'(scale) * 64'(high_slot)) / 64'(r.total_width);
            r.duty = quotient[DUTY_W-1:0];
         end
         due_readings.push_back(r);
         captures++;
      endfunction

      function void check_field(string name, longint unsigned want, longint unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void match_reading(logic [RSP_D_W-1:0] data, logic [RSP_U_W-1:0] user);
         pwm_reading_type want;
         readings++;
         if (due_readings.size() == 0) begin
            $error("reading with no capture pending: data %h user %b", data, user);
            errors++;
            return;
         end
         want = due_readings.pop_front();
         check_field("high_width", want.high_width, data[15:0]);
         check_field("low_width", want.low_width, data[31:16]);
         check_field("total_width", want.total_width, data[48:32]);
         check_field("frequency", want.frequency, data[64:49]);
         check_field("duty", want.duty, data[78:65]);
         check_field("zero_period", want.zero_period, user[0]);
         check_field("stored_high", want.stored_high, user[1]);
      endfunction

      function int pending();
         return due_readings.size();
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [CAP_W-1:0]   req_tdata = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_D_W-1:0] rsp_tdata;
   logic [RSP_U_W-1:0] rsp_tuser;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CSR_A_W-1:0] csr_addr = '0;
   logic [CLK_W-1:0]   csr_wdata = '0;

   pwm_reading_checker board = new();
   bit                 steady = 1'b0;
   int                 cycles = 0;
   int                 settings = 0;

   pwm_capture_freq_duty i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d readings pending", cycles, board.pending());
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 12);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.log_capture(req_tdata);
         if (rsp_tvalid && rsp_tready) board.match_reading(rsp_tdata, rsp_tuser);
      end
   end

   task automatic send_capture(logic [CAP_W-1:0] value);
      while (!steady && $urandom_range(0, 99) < 12) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_register(logic [CSR_A_W-1:0] index, logic [CLK_W-1:0] value);
      csr_valid <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      board.set_register(index, value);
   endtask

   // registers only change once every reading is back
   task automatic configure(logic [CLK_W-1:0] clock_hz, logic [CLK_W-1:0] scale);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      write_register(CSR_CLOCK_HZ, clock_hz);
      write_register($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI, CLK_W'($urandom));
      write_register(CSR_DUTY_SCALE, scale);
      csr_valid <= 1'b0;
      settings++;
   endtask

   function automatic logic [CAP_W-1:0] random_capture();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1: return CAP_W'($urandom_range(0, 15));
         2: return CAP_W'($urandom_range(65520, 65535));
         3: return '0;
         default: return CAP_W'($urandom_range(0, 65535));
      endcase
   endfunction

   initial begin
      logic [CLK_W-1:0] phase_hz[7];
      logic [CLK_W-1:0] phase_scale[7];
      int               drain;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: zero period, saturation, full-scale widths
      send_capture(16'd0);
      send_capture(16'd0);
      send_capture(16'd1);
      send_capture(16'd0);
      send_capture(16'hFFFF);
      send_capture(16'hFFFF);
      send_capture(16'd0);
      send_capture(16'h5555);
      send_capture(16'hAAAA);
      send_capture(16'h0001);

      configure(CLK_HZ_TOP, CLK_W'(SCALE_TOP));
      send_capture(16'd1);
      send_capture(16'd1);
      send_capture(16'hFFFF);
      send_capture(16'd0);

      // zero clock and zero scale
      configure('0, '0);
      send_capture(16'd5);
      send_capture(16'd7);
      send_capture(16'd0);

      // registers beyond their stated ranges
      configure('1, '1);
      send_capture(16'hFFFF);
      send_capture(16'd1);
      send_capture(16'd1);
      send_capture(16'hFFFF);

      phase_hz    = '{CLK_W'(375000), CLK_HZ_TOP, CLK_W'(1), CLK_W'($urandom_range(1, 24000000)),
                      CLK_W'($urandom), '0, '1};
      phase_scale = '{CLK_W'(100), CLK_W'(SCALE_TOP), CLK_W'(1), CLK_W'($urandom_range(1, 10000)),
                      CLK_W'($urandom), '0, '1};
      for (int p = 0; p < 7; p++) begin
         configure(phase_hz[p], phase_scale[p]);
         steady = (p == 2);
         for (int n = 0; n < 285; n++) send_capture(random_capture());
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;

      drain = 0;
      while (board.pending() != 0 && drain < 20000) begin
         @(posedge clock);
         drain++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.pending() != 0) begin
         $error("%0d readings never arrived", board.pending());
         board.errors++;
      end

      $display("sent %0d captures and checked %0d readings over %0d register settings",
               board.captures, board.readings, settings);
      $display("settings included zero, in-range extremes and full-width register values");
      if (board.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
